>>> hdl/lpra_pkg.sv
// Package for the lidar projection and box assignment block.
// Item types, field widths, pipeline depths and register codes.
// Used by every module under hdl.
package lpra_pkg;

	localparam int MAX_BOXES = 16;
	localparam int BIW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNTW = $clog2(MAX_BOXES + 1);
	localparam int NCOEF = 12;

	// projection sums, their magnitudes, quotient bits and remainder width
	localparam int YW = 50;
	localparam int AW = 49;
	localparam int QB = 17;
	localparam int RW = AW + QB + 1;

	// pipeline depths
	localparam int PROJ_LAT = 2;
	localparam int DIV_LAT = QB + 3;
	localparam int PRE_LAT = PROJ_LAT + DIV_LAT;

	localparam int AddrW = 3;
	localparam logic REG_SHRINK = 1'b0;

	typedef enum logic [1:0] {
		KIND_COEF  = 2'd0,
		KIND_BOX   = 2'd1,
		KIND_POINT = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [3:0]          slot;
		logic signed [31:0]  coef_value;
		logic signed [15:0]  box_left;
		logic signed [15:0]  box_top;
		logic [14:0]         box_width;
		logic [14:0]         box_height;
		logic [7:0]          box_label;
		logic signed [15:0]  point_x;
		logic signed [15:0]  point_y;
		logic signed [15:0]  point_z;
	} in_t;

	typedef struct packed {
		logic                matched;
		logic [7:0]          match_label;
		logic [3:0]          match_slot;
		logic [4:0]          enclosing_count;
		logic signed [15:0]  pixel_col;
		logic signed [15:0]  pixel_row;
		logic                depth_zero;
		logic                saturated;
	} out_t;

	// shrunk box, edges half-open: left <= col < right, top <= row < bottom
	typedef struct packed {
		logic signed [16:0]  left;
		logic signed [17:0]  right;
		logic signed [16:0]  top;
		logic signed [17:0]  bottom;
	} box_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot;
		box_t        box;
		logic [7:0]  label;
		logic        dz;
	} ctl_t;

	typedef struct packed {
		logic signed [YW-1:0] y0;
		logic signed [YW-1:0] y1;
		logic signed [YW-1:0] y2;
	} yvec_t;

endpackage

>>> hdl/lidar_projection_roi_assign.sv
// Lidar point to camera box assignment, top level.
// Uses lpra_pkg, lpra_proj, lpra_div and lpra_match.

// Points, coefficient loads, box loads and clears enter one per cycle unless the
// output stalls, and move through a 24-stage pipeline: two stages of matrix
// multiply and sum, twenty stages of the divider (one quotient bit per step
// stage for both pixel coordinates), then the box test and the selection/output
// register. Only points give results. Matrix writes take effect for points taken
// after them, box loads and clears at their place in the item order. The shrink
// factor is sampled when a box is taken.
module lidar_projection_roi_assign (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpra_pkg::in_t       in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output lpra_pkg::out_t      out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [lpra_pkg::AddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import lpra_pkg::*;

	logic        adv, acc;
	logic [7:0]  shrink_q;
	logic        v_s    [1:PRE_LAT];
	ctl_t        ctl_s  [1:PRE_LAT];
	ctl_t        ctl_dz;
	yvec_t       y_s2;
	logic signed [15:0] col, row;
	logic        clip_c, clip_r;

	logic signed [26:0] lnum, tnum;
	logic signed [17:0] lsh, tsh;
	logic [23:0]        wprod, hprod;
	ctl_t               ctl_in;

	assign pready = 1'b1;
	assign prdata = {24'd0, shrink_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shrink_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_SHRINK) begin
			shrink_q <= pwdata[7:0];
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign acc      = in_valid && in_ready;

	// box shrink: corners move in by s/512 of the size, truncated toward zero
	always_comb begin
		lnum  = (27'(in_item.box_left) <<< 9)
			+ $signed({4'd0, 23'(shrink_q) * 23'(in_item.box_width)});
		tnum  = (27'(in_item.box_top)  <<< 9)
			+ $signed({4'd0, 23'(shrink_q) * 23'(in_item.box_height)});
		lsh   = 18'(lnum >>> 9) + 18'(lnum[26] && lnum[8:0] != 9'd0);
		tsh   = 18'(tnum >>> 9) + 18'(tnum[26] && tnum[8:0] != 9'd0);
		wprod = in_item.box_width  * (9'd256 - 9'(shrink_q));
		hprod = in_item.box_height * (9'd256 - 9'(shrink_q));
		ctl_in.kind       = in_item.kind;
		ctl_in.slot       = in_item.slot;
		ctl_in.label      = in_item.box_label;
		ctl_in.dz         = 1'b0;
		ctl_in.box.left   = lsh[16:0];
		ctl_in.box.top    = tsh[16:0];
		ctl_in.box.right  = lsh + $signed({3'd0, wprod[22:8]});
		ctl_in.box.bottom = tsh + $signed({3'd0, hprod[22:8]});
	end

	// depth row is known once the sums are in
	always_comb begin
		ctl_dz    = ctl_s[PROJ_LAT];
		ctl_dz.dz = y_s2.y2 == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PRE_LAT; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= acc;
			for (int i = 2; i <= PRE_LAT; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[1] <= ctl_in;
			for (int i = 2; i <= PRE_LAT; i++)
				ctl_s[i] <= (i == PROJ_LAT + 1) ? ctl_dz : ctl_s[i-1];
		end
	end

	lpra_proj u_proj (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.acc    (acc),
		.item   (in_item),
		.y_s2   (y_s2)
	);

	lpra_div u_div_col (
		.clk  (clk),
		.adv  (adv),
		.num  (y_s2.y0),
		.den  (y_s2.y2),
		.quo  (col),
		.clip (clip_c)
	);

	lpra_div u_div_row (
		.clk  (clk),
		.adv  (adv),
		.num  (y_s2.y1),
		.den  (y_s2.y2),
		.quo  (row),
		.clip (clip_r)
	);

	lpra_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vin       (v_s[PRE_LAT]),
		.ctl       (ctl_s[PRE_LAT]),
		.col       (col),
		.row       (row),
		.sat       (clip_c || clip_r),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

`ifndef NO_ASSERTIONS
	a_match_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.matched |-> out_item.enclosing_count == 5'd1)
		else $error("matched item with count other than one");

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.depth_zero |-> !out_item.matched
			&& out_item.enclosing_count == 5'd0 && !out_item.saturated)
		else $error("zero depth item carries a match");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");
`endif

endmodule

>>> hdl/lpra_proj.sv
// Projection matrix store and two-stage multiply / sum pipeline.
// Depends on lpra_pkg.
module lpra_proj (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           acc,
	input  lpra_pkg::in_t  item,
	output lpra_pkg::yvec_t y_s2
);
	import lpra_pkg::*;

	logic signed [31:0] coef_q [NCOEF];
	logic signed [47:0] prod_s1 [3][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
		end else if (acc && item.kind == KIND_COEF && item.slot < 4'(NCOEF)) begin
			coef_q[item.slot] <= item.coef_value;
		end
	end

	// products read the matrix as it stands when the point is taken
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= coef_q[r*4]     * item.point_x;
				prod_s1[r][1] <= coef_q[r*4 + 1] * item.point_y;
				prod_s1[r][2] <= coef_q[r*4 + 2] * item.point_z;
				prod_s1[r][3] <= {{8{coef_q[r*4 + 3][31]}}, coef_q[r*4 + 3], 8'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2.y0 <= YW'(prod_s1[0][0]) + YW'(prod_s1[0][1])
				+ YW'(prod_s1[0][2]) + YW'(prod_s1[0][3]);
			y_s2.y1 <= YW'(prod_s1[1][0]) + YW'(prod_s1[1][1])
				+ YW'(prod_s1[1][2]) + YW'(prod_s1[1][3]);
			y_s2.y2 <= YW'(prod_s1[2][0]) + YW'(prod_s1[2][1])
				+ YW'(prod_s1[2][2]) + YW'(prod_s1[2][3]);
		end
	end

endmodule

>>> hdl/lpra_div.sv
// Pipelined signed divider, one quotient bit per step stage, truncating
// toward zero and saturating to 16 bits. Depends on lpra_pkg.
module lpra_div (
	input  logic                         clk,
	input  logic                         adv,
	input  logic signed [lpra_pkg::YW-1:0] num,
	input  logic signed [lpra_pkg::YW-1:0] den,
	output logic signed [15:0]           quo,
	output logic                         clip
);
	import lpra_pkg::*;

	logic [AW-1:0] nabs_q, dabs_q;
	logic          neg_q;

	logic [RW-1:0] rem_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [AW-1:0] den_s [QB+1];
	logic          neg_s [QB+1];
	logic          big_s [QB+1];

	logic signed [YW-1:0] nneg, dneg;
	logic signed [QB:0]   sval;

	assign nneg = -num;
	assign dneg = -den;

	always_ff @(posedge clk) begin
		if (adv) begin
			nabs_q <= num[YW-1] ? nneg[AW-1:0] : num[AW-1:0];
			dabs_q <= den[YW-1] ? dneg[AW-1:0] : den[AW-1:0];
			neg_q  <= num[YW-1] ^ den[YW-1];
		end
	end

	// quotient at or above 2^QB saturates whatever its low bits are
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= RW'(nabs_q);
			quo_s[0] <= '0;
			den_s[0] <= dabs_q;
			neg_s[0] <= neg_q;
			big_s[0] <= RW'(nabs_q) >= (RW'(dabs_q) << QB);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] sub;
		assign sub = RW'(den_s[k]) << (QB - 1 - k);
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_s[k] >= sub) begin
					rem_s[k+1] <= rem_s[k] - sub;
					quo_s[k+1] <= quo_s[k] | (QB'(1) << (QB - 1 - k));
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
				end
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
			end
		end
	end

	assign sval = neg_s[QB] ? -$signed({1'b0, quo_s[QB]}) : $signed({1'b0, quo_s[QB]});

	always_ff @(posedge clk) begin
		if (adv) begin
			if (big_s[QB]) begin
				quo  <= neg_s[QB] ? 16'sh8000 : 16'sh7fff;
				clip <= 1'b1;
			end else if (sval > (QB+1)'(32767)) begin
				quo  <= 16'sh7fff;
				clip <= 1'b1;
			end else if (sval < -(QB+1)'(32768)) begin
				quo  <= 16'sh8000;
				clip <= 1'b1;
			end else begin
				quo  <= sval[15:0];
				clip <= 1'b0;
			end
		end
	end

	logic unused_rem;
	assign unused_rem = ^rem_s[QB] ^ ^den_s[QB];

endmodule

>>> hdl/lpra_match.sv
// Box slots and the two-stage containment test and selection.
// Box loads and clears update the slots in pipeline order. Depends on lpra_pkg.
module lpra_match (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vin,
	input  lpra_pkg::ctl_t    ctl,
	input  logic signed [15:0] col,
	input  logic signed [15:0] row,
	input  logic              sat,
	output logic              out_valid,
	output lpra_pkg::out_t    out_item
);
	import lpra_pkg::*;

	box_t                 bnd_q [MAX_BOXES];
	logic [7:0]           lab_q [MAX_BOXES];
	logic [MAX_BOXES-1:0] bval_q;

	logic [MAX_BOXES-1:0] hit, hit_a;
	logic                 va;
	logic signed [15:0]   col_a, row_a;
	logic                 dz_a, sat_a;
	logic                 wr_box;

	logic [6:0]           cnt;
	logic [BIW-1:0]       found;
	logic [CNTW-1:0]      pc;

	assign wr_box = adv && vin && ctl.kind == KIND_BOX && 7'(ctl.slot) < 7'(MAX_BOXES);

	always_comb begin
		for (int i = 0; i < MAX_BOXES; i++) begin
			hit[i] = bval_q[i] && !ctl.dz
				&& 18'(col) >= 18'(bnd_q[i].left) && 18'(col) < bnd_q[i].right
				&& 18'(row) >= 18'(bnd_q[i].top) && 18'(row) < bnd_q[i].bottom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bval_q <= '0;
		end else if (adv && vin && ctl.kind == KIND_CLEAR) begin
			bval_q <= '0;
		end else if (wr_box) begin
			bval_q[ctl.slot[BIW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_box) begin
			bnd_q[ctl.slot[BIW-1:0]] <= ctl.box;
			lab_q[ctl.slot[BIW-1:0]] <= ctl.label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va        <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			va        <= vin && ctl.kind == KIND_POINT;
			out_valid <= va;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_a <= hit;
			col_a <= ctl.dz ? '0 : col;
			row_a <= ctl.dz ? '0 : row;
			sat_a <= ctl.dz ? 1'b0 : sat;
			dz_a  <= ctl.dz;
		end
	end

	// last enclosing slot wins; only used when exactly one encloses
	always_comb begin
		pc    = '0;
		found = '0;
		for (int i = 0; i < MAX_BOXES; i++) begin
			pc = pc + CNTW'(hit_a[i]);
			if (hit_a[i]) found = BIW'(i);
		end
		cnt = 7'(pc);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item.enclosing_count <= (cnt > 7'd31) ? 5'd31 : cnt[4:0];
			out_item.matched         <= cnt == 7'd1;
			out_item.match_label     <= (cnt == 7'd1) ? lab_q[found] : 8'd0;
			out_item.match_slot      <= (cnt == 7'd1) ? 4'(found) : 4'd0;
			out_item.pixel_col       <= col_a;
			out_item.pixel_row       <= row_a;
			out_item.depth_zero      <= dz_a;
			out_item.saturated       <= sat_a;
		end
	end

endmodule
